### hdl/pbd_pkg.sv
`timescale 1ns / 1ps
package pbd_pkg;

  localparam int DEF_SRC_WIDTH     = 640;
  localparam int DEF_SRC_HEIGHT    = 480;
  localparam int DEF_BACKLOG_DEPTH = 2048;

  localparam int FRAC_ONE = 65536;

  localparam int DST_ROWS [4] = '{480, 320, 213, 142};
  localparam int DST_COLS [4] = '{640, 427, 284, 190};

  localparam logic [2:0] ADDR_LEVEL = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic wgt;
    logic mul;
    logic sum;
  } ictl_t;

  function automatic logic [31:0] axis_offset(logic [31:0] rate);
    logic [31:0] h;
    h = (rate >> 1) - 32'd32768;
    return ((h + 32'd32) >> 6) << 6;
  endfunction

  // Last grid index whose mapped source coordinate is one behind it.
  function automatic int last_write(int n, logic [31:0] rate, logic [31:0] off);
    int last;
    int s;
    logic [31:0] rem;
    logic [31:0] p;
    logic [31:0] f;
    last = -1;
    rem = '0;
    p = '0;
    for (int k = 0; k < n; k++) begin
      f = p + off;
      s = int'(f[31:16]);
      if (s > n - 1) s = n - 1;
      if (s == k - 1) last = k;
      rem = rem + 32'(FRAC_ONE);
      if (rem >= rate) begin
        rem = rem - rate;
        p = p + rate;
      end
    end
    return last;
  endfunction

endpackage

### hdl/pbd_ram.sv
`timescale 1ns / 1ps
module pbd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/pbd_interp.sv
`timescale 1ns / 1ps
module pbd_interp import pbd_pkg::*; (
  input  logic        clk,
  input  ictl_t       ctl,
  input  logic [15:0] fu,
  input  logic [15:0] fv,
  input  logic        cu,
  input  logic        cv,
  input  logic [7:0]  win00,
  input  logic [7:0]  win01,
  input  logic [7:0]  win10,
  input  logic [7:0]  win11,
  output logic [7:0]  result
);

  logic [16:0] u1, v1, u, v;
  logic [33:0] w11_r, w10_r, w01_r, w00_r;
  logic [41:0] p11_r, p10_r, p01_r, p00_r;
  logic [43:0] t, tr;

  assign u1 = 17'(FRAC_ONE) - {1'b0, fu};
  assign v1 = 17'(FRAC_ONE) - {1'b0, fv};
  assign u  = cu ? 17'd0 : {1'b0, fu};
  assign v  = cv ? 17'd0 : {1'b0, fv};

  always_ff @(posedge clk) begin
    if (ctl.wgt) begin
      w11_r <= u1 * v1;
      w10_r <= u * v1;
      w01_r <= u1 * v;
      w00_r <= u * v;
    end
    if (ctl.mul) begin
      p11_r <= 42'(win11) * 42'(w11_r);
      p10_r <= 42'(win10) * 42'(w10_r);
      p01_r <= 42'(win01) * 42'(w01_r);
      p00_r <= 42'(win00) * 42'(w00_r);
    end
    if (ctl.sum) begin
      result <= (tr[43:32] > 12'd255) ? 8'd255 : tr[39:32];
    end
  end

  assign t  = 44'(p11_r) + 44'(p10_r) + 44'(p01_r) + 44'(p00_r);
  assign tr = t + 44'h0_8000_0000;

endmodule

### hdl/pyramid_bilinear_downscaler.sv
`timescale 1ns / 1ps
// A passthrough item goes from ST_IDLE to ST_OUT, which registers out_valid; a resize item
// goes through ST_READ and ST_UPD, then ST_MUL, ST_SUM and ST_OUT if it yields a result,
// else back to ST_IDLE. The input stalls outside ST_IDLE, so no new item is taken before
// the last is through, and ST_OUT holds while a result is stalled; the read, update and
// write-back of line store and backlog memories plus the multiply and sum make these steps.
// Reset: synchronous active-low rst_n clears control state and the window; the memories
// are not cleared and need no clearing pass.
module pyramid_bilinear_downscaler import pbd_pkg::*; #(
  parameter int SRC_WIDTH     = DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT    = DEF_SRC_HEIGHT,
  parameter int BACKLOG_DEPTH = DEF_BACKLOG_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  input  logic        in_first_of_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel,
  output logic        out_last_of_frame,
  output logic        out_backlog_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(SRC_WIDTH);
  localparam int RW = $clog2(SRC_HEIGHT);
  localparam int XD = SRC_WIDTH + 1;
  localparam int XW = $clog2(XD);
  localparam int HW = $clog2(BACKLOG_DEPTH);
  localparam int NW = $clog2(BACKLOG_DEPTH + 1);

  localparam logic [31:0] ROW_STEP [4] = '{
    32'((SRC_HEIGHT * FRAC_ONE) / DST_ROWS[0]), 32'((SRC_HEIGHT * FRAC_ONE) / DST_ROWS[1]),
    32'((SRC_HEIGHT * FRAC_ONE) / DST_ROWS[2]), 32'((SRC_HEIGHT * FRAC_ONE) / DST_ROWS[3])};
  localparam logic [31:0] COL_STEP [4] = '{
    32'((SRC_WIDTH * FRAC_ONE) / DST_COLS[0]), 32'((SRC_WIDTH * FRAC_ONE) / DST_COLS[1]),
    32'((SRC_WIDTH * FRAC_ONE) / DST_COLS[2]), 32'((SRC_WIDTH * FRAC_ONE) / DST_COLS[3])};
  localparam logic [31:0] ROW_OFF [4] = '{
    axis_offset(ROW_STEP[0]), axis_offset(ROW_STEP[1]),
    axis_offset(ROW_STEP[2]), axis_offset(ROW_STEP[3])};
  localparam logic [31:0] COL_OFF [4] = '{
    axis_offset(COL_STEP[0]), axis_offset(COL_STEP[1]),
    axis_offset(COL_STEP[2]), axis_offset(COL_STEP[3])};
  localparam logic [RW:0] LAST_ROW [4] = '{
    (RW+1)'(last_write(SRC_HEIGHT, ROW_STEP[0], ROW_OFF[0])),
    (RW+1)'(last_write(SRC_HEIGHT, ROW_STEP[1], ROW_OFF[1])),
    (RW+1)'(last_write(SRC_HEIGHT, ROW_STEP[2], ROW_OFF[2])),
    (RW+1)'(last_write(SRC_HEIGHT, ROW_STEP[3], ROW_OFF[3]))};
  localparam logic [CW:0] LAST_COL [4] = '{
    (CW+1)'(last_write(SRC_WIDTH, COL_STEP[0], COL_OFF[0])),
    (CW+1)'(last_write(SRC_WIDTH, COL_STEP[1], COL_OFF[1])),
    (CW+1)'(last_write(SRC_WIDTH, COL_STEP[2], COL_OFF[2])),
    (CW+1)'(last_write(SRC_WIDTH, COL_STEP[3], COL_OFF[3]))};
  localparam logic [3:0] RESIZE = {
    (SRC_HEIGHT > DST_ROWS[3]) && (SRC_WIDTH > DST_COLS[3]),
    (SRC_HEIGHT > DST_ROWS[2]) && (SRC_WIDTH > DST_COLS[2]),
    (SRC_HEIGHT > DST_ROWS[1]) && (SRC_WIDTH > DST_COLS[1]),
    1'b0};

  localparam logic [15:0] W_LAST = 16'(SRC_WIDTH - 1);
  localparam logic [15:0] H_LAST = 16'(SRC_HEIGHT - 1);

  state_t state_r, state_nxt;
  logic [1:0] level_r;

  logic [CW-1:0] grid_col_r, grid_col_nxt;
  logic [RW-1:0] grid_row_r, grid_row_nxt;
  logic [XW-1:0] fetch_col_r, fetch_col_nxt;
  logic [31:0] crem_r [4], crem_nxt [4];
  logic [31:0] cp_r [4], cp_nxt [4];
  logic [31:0] rrem_r [4], rrem_nxt [4];
  logic [31:0] rp_r [4], rp_nxt [4];

  logic [7:0] win00_r, win01_r, win10_r, win11_r;
  logic [7:0] last_read_r;
  logic [HW-1:0] head_r;
  logic [NW-1:0] count_r;
  logic ovf_r;

  logic [7:0] pix_r;
  logic [15:0] fu_r, fv_r;
  logic cu_r, cv_r, pop_en_r, wr_en_r, emit_r, last_r, resize_r;
  logic [XW-1:0] x_r;

  logic out_valid_r;
  logic [7:0] out_pixel_r;
  logic out_last_r, out_ovf_r;

  logic accept, ff, at_origin, col_wrap, row_wrap, resize_now;
  logic [CW-1:0] j;
  logic [RW-1:0] i;
  logic [XW-1:0] x;
  logic [31:0] cp_e [4], crem_e [4], rp_e [4], rrem_e [4];
  logic [31:0] fc, fr;
  logic [15:0] sx, sy;
  logic cu, cv;

  logic [7:0] line_rdata, q_rdata, pop_val;
  logic line_we;
  logic [7:0] line_wdata;
  logic q_we;
  logic [HW:0] tail_sum;
  logic [HW-1:0] tail;
  logic [7:0] interp_result;
  ictl_t ictl;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign ff = in_first_of_frame;
  assign j = ff ? '0 : grid_col_r;
  assign i = ff ? '0 : grid_row_r;
  assign at_origin = (j == '0) && (i == '0);
  assign col_wrap = (j == CW'(SRC_WIDTH - 1));
  assign row_wrap = (i == RW'(SRC_HEIGHT - 1));
  assign resize_now = RESIZE[level_r];
  assign x = (j == '0) ? '0 : fetch_col_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cp_e[l]   = ff ? '0 : cp_r[l];
      crem_e[l] = ff ? '0 : crem_r[l];
      rp_e[l]   = ff ? '0 : rp_r[l];
      rrem_e[l] = ff ? '0 : rrem_r[l];
    end
  end

  assign fc = cp_e[level_r] + COL_OFF[level_r];
  assign fr = rp_e[level_r] + ROW_OFF[level_r];
  assign cu = (fc[31:16] > W_LAST);
  assign cv = (fr[31:16] > H_LAST);
  assign sx = cu ? W_LAST : fc[31:16];
  assign sy = cv ? H_LAST : fr[31:16];

  always_comb begin
    grid_col_nxt  = grid_col_r;
    grid_row_nxt  = grid_row_r;
    fetch_col_nxt = fetch_col_r;
    for (int l = 0; l < 4; l++) begin
      crem_nxt[l] = crem_r[l];
      cp_nxt[l]   = cp_r[l];
      rrem_nxt[l] = rrem_r[l];
      rp_nxt[l]   = rp_r[l];
    end
    if (accept) begin
      grid_col_nxt = col_wrap ? '0 : j + 1'b1;
      grid_row_nxt = col_wrap ? (row_wrap ? '0 : i + 1'b1) : i;
      if (resize_now) begin
        fetch_col_nxt = (x < XW'(SRC_WIDTH)) ? x + 1'b1 : x;
      end
      for (int l = 0; l < 4; l++) begin
        if (col_wrap) begin
          crem_nxt[l] = '0;
          cp_nxt[l]   = '0;
          if (row_wrap) begin
            rrem_nxt[l] = '0;
            rp_nxt[l]   = '0;
          end else if (rrem_e[l] + 32'(FRAC_ONE) >= ROW_STEP[l]) begin
            rrem_nxt[l] = rrem_e[l] + 32'(FRAC_ONE) - ROW_STEP[l];
            rp_nxt[l]   = rp_e[l] + ROW_STEP[l];
          end else begin
            rrem_nxt[l] = rrem_e[l] + 32'(FRAC_ONE);
            rp_nxt[l]   = rp_e[l];
          end
        end else begin
          rrem_nxt[l] = rrem_e[l];
          rp_nxt[l]   = rp_e[l];
          if (crem_e[l] + 32'(FRAC_ONE) >= COL_STEP[l]) begin
            crem_nxt[l] = crem_e[l] + 32'(FRAC_ONE) - COL_STEP[l];
            cp_nxt[l]   = cp_e[l] + COL_STEP[l];
          end else begin
            crem_nxt[l] = crem_e[l] + 32'(FRAC_ONE);
            cp_nxt[l]   = cp_e[l];
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ictl = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = resize_now ? ST_READ : ST_OUT;
      end
      ST_READ: begin
        ictl.wgt = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = emit_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        ictl.mul = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        ictl.sum = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign pop_val = (count_r == '0) ? pix_r : q_rdata;
  assign line_we = (state_r == ST_UPD) && wr_en_r;
  assign line_wdata = pop_en_r ? pop_val : last_read_r;
  assign q_we = (state_r == ST_UPD) && (count_r < NW'(BACKLOG_DEPTH));
  assign tail_sum = (HW+1)'(head_r) + (HW+1)'(count_r);
  assign tail = (tail_sum >= (HW+1)'(BACKLOG_DEPTH)) ?
                HW'(tail_sum - (HW+1)'(BACKLOG_DEPTH)) : tail_sum[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      grid_col_r  <= '0;
      grid_row_r  <= '0;
      fetch_col_r <= '0;
      for (int l = 0; l < 4; l++) begin
        crem_r[l] <= '0;
        cp_r[l]   <= '0;
        rrem_r[l] <= '0;
        rp_r[l]   <= '0;
      end
      win00_r     <= '0;
      win01_r     <= '0;
      win10_r     <= '0;
      win11_r     <= '0;
      last_read_r <= '0;
      head_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grid_col_r  <= grid_col_nxt;
      grid_row_r  <= grid_row_nxt;
      fetch_col_r <= fetch_col_nxt;
      for (int l = 0; l < 4; l++) begin
        crem_r[l] <= crem_nxt[l];
        cp_r[l]   <= cp_nxt[l];
        rrem_r[l] <= rrem_nxt[l];
        rp_r[l]   <= rp_nxt[l];
      end
      if (psel && penable && pwrite && (paddr[2] == ADDR_LEVEL[2])) begin
        level_r <= pwdata[1:0];
      end
      if (accept && at_origin) begin
        head_r  <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (state_r == ST_UPD) begin
        win01_r <= win00_r;
        win11_r <= win10_r;
        win10_r <= line_rdata;
        if (pop_en_r) begin
          last_read_r <= pop_val;
          win00_r <= pop_val;
          head_r <= (head_r == HW'(BACKLOG_DEPTH - 1)) ? '0 : head_r + 1'b1;
        end else if (!wr_en_r) begin
          win00_r <= line_rdata;
        end
        if (count_r < NW'(BACKLOG_DEPTH)) begin
          count_r <= pop_en_r ? count_r : count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
          count_r <= pop_en_r ? count_r - 1'b1 : count_r;
        end
      end
      if ((state_r == ST_OUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r    <= in_pixel;
      fu_r     <= fc[15:0];
      fv_r     <= fr[15:0];
      cu_r     <= cu;
      cv_r     <= cv;
      wr_en_r  <= (sy < H_LAST);
      pop_en_r <= (sy < H_LAST) && (sx < W_LAST);
      emit_r   <= (i != '0) && (j != '0) && (sy == 16'(i) - 16'd1) && (sx == 16'(j) - 16'd1);
      resize_r <= resize_now;
      last_r   <= resize_now ?
                  (({1'b0, i} == LAST_ROW[level_r]) && ({1'b0, j} == LAST_COL[level_r])) :
                  (row_wrap && col_wrap);
      x_r      <= x;
    end
    if ((state_r == ST_OUT) && (!out_valid_r || !out_stall)) begin
      out_pixel_r <= resize_r ? interp_result : pix_r;
      out_last_r  <= last_r;
      out_ovf_r   <= ovf_r;
    end
  end

  pbd_ram #(.DATA_W(8), .DEPTH(XD)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (x_r),
    .wdata (line_wdata),
    .re    (state_r == ST_READ),
    .raddr (x_r),
    .rdata (line_rdata)
  );

  pbd_ram #(.DATA_W(8), .DEPTH(BACKLOG_DEPTH)) u_backlog (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (pix_r),
    .re    (state_r == ST_READ),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  pbd_interp u_interp (
    .clk    (clk),
    .ctl    (ictl),
    .fu     (fu_r),
    .fv     (fv_r),
    .cu     (cu_r),
    .cv     (cv_r),
    .win00  (win00_r),
    .win01  (win01_r),
    .win10  (win10_r),
    .win11  (win11_r),
    .result (interp_result)
  );

  assign out_valid            = out_valid_r;
  assign out_pixel            = out_pixel_r;
  assign out_last_of_frame    = out_last_r;
  assign out_backlog_overflow = out_ovf_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_LEVEL[2]) ? {30'd0, level_r} : 32'd0;

endmodule

### hdl/pbd_checker.sv
`timescale 1ns / 1ps
module pbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("stalled result changed");

  // Every accepted item moves the state out of ST_IDLE, so the input stalls after it.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pyramid_bilinear_downscaler pbd_checker u_pbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_pixel (out_pixel)
);

### bench/pyramid_bilinear_downscaler_tb.sv
`timescale 1ns / 1ps
module pyramid_bilinear_downscaler_tb;
  import pbd_pkg::*;

  localparam int W = DEF_SRC_WIDTH;
  localparam int H = DEF_SRC_HEIGHT;
  localparam int QDEPTH = DEF_BACKLOG_DEPTH;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       ovf;
  } pix_res_t;

  typedef struct {
    logic [7:0] pixel;
    logic       first;
    logic       typed;
    pix_res_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_pixel = '0;
  logic in_first_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_pixel;
  logic out_last_of_frame;
  logic out_backlog_overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic row_typed = 1'b0;
  pix_res_t row_res = '0;

  always #1 clk = ~clk;

  pyramid_bilinear_downscaler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .in_first_of_frame(in_first_of_frame),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .out_last_of_frame(out_last_of_frame), .out_backlog_overflow(out_backlog_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Downscaler predictor state.
  logic [1:0] lvl;
  bit shrink_on;
  longint unsigned rate_r, rate_c;
  longint off_r, off_c;
  int last_row_wr, last_col_wr;
  logic [7:0] lstore0 [0:W];
  logic [7:0] win00, win01, win10, win11;
  int g_row, g_col, f_col;
  logic [7:0] last_pix;
  logic [7:0] backlog [$];
  bit ovf_flag;

  pix_res_t pix_expect [$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  bit quiet = 1'b0;

  function automatic int map_coord(int k, longint unsigned rate, longint off, int n,
                                   output longint unsigned frac, output bit clamped);
    longint unsigned d;
    longint f;
    int s;
    d = (longint'(k) << 16) / rate;
    f = longint'(d * rate) + off;
    s = int'(f >>> 16);
    frac = longint'(f & 64'hFFFF);
    clamped = 1'b0;
    if (s > n - 1) begin
      s = n - 1;
      clamped = 1'b1;
    end
    return s;
  endfunction

  function automatic longint half_offset(longint unsigned rate);
    longint unsigned h;
    h = (rate >> 1) - 64'd32768;
    return longint'(((h + 64'd32) >> 6) << 6);
  endfunction

  function automatic int final_write(int n, longint unsigned rate, longint off);
    int last;
    longint unsigned fr;
    bit cl;
    last = -1;
    for (int k = 0; k < n; k++)
      if (map_coord(k, rate, off, n, fr, cl) == k - 1) last = k;
    return last;
  endfunction

  function automatic void set_level(logic [1:0] v);
    int dr;
    int dc;
    lvl = v;
    dr = DST_ROWS[v];
    dc = DST_COLS[v];
    shrink_on = (v != 0) && (H > dr) && (W > dc);
    if (shrink_on) begin
      rate_r = (longint'(H) << 16) / dr;
      rate_c = (longint'(W) << 16) / dc;
      off_r = half_offset(rate_r);
      off_c = half_offset(rate_c);
      last_row_wr = final_write(H, rate_r, off_r);
      last_col_wr = final_write(W, rate_c, off_c);
    end
  endfunction

  function automatic logic [7:0] backlog_pop();
    logic [7:0] v;
    v = last_pix;
    if (backlog.size() > 0) v = backlog.pop_front();
    return v;
  endfunction

  function automatic bit downscale_step(logic [7:0] pix, logic first, output pix_res_t r);
    int i;
    int j;
    int sy;
    int sx;
    int x;
    bit end_pos;
    bit cu;
    bit cv;
    longint unsigned fu, fv, u, v, u1, v1, t, rr;
    if (first) begin
      g_row = 0;
      g_col = 0;
    end
    if (g_row == 0 && g_col == 0) begin
      backlog.delete();
      ovf_flag = 1'b0;
    end
    i = g_row;
    j = g_col;
    end_pos = (i == H - 1) && (j == W - 1);
    g_col++;
    if (g_col >= W) begin
      g_col = 0;
      g_row++;
      if (g_row >= H) g_row = 0;
    end
    if (!shrink_on) begin
      r = '{pixel: pix, last: end_pos, ovf: ovf_flag};
      return 1'b1;
    end
    if (backlog.size() < QDEPTH) backlog.push_back(pix);
    else ovf_flag = 1'b1;
    if (j == 0) f_col = 0;
    sy = map_coord(i, rate_r, off_r, H, fv, cv);
    sx = map_coord(j, rate_c, off_c, W, fu, cu);
    u1 = 65536 - fu;
    v1 = 65536 - fv;
    u = cu ? 0 : fu;
    v = cv ? 0 : fv;
    x = (f_col > W) ? W : f_col;
    win01 = win00;
    win11 = win10;
    win10 = lstore0[x];
    if (sy < H - 1 && sx < W - 1) begin
      last_pix = backlog_pop();
      lstore0[x] = last_pix;
      win00 = last_pix;
    end else if (sy < H - 1) begin
      lstore0[x] = last_pix;
    end else begin
      win00 = lstore0[x];
    end
    if (f_col < W) f_col++;
    if (!(sy == i - 1 && sx == j - 1)) return 1'b0;
    t = longint'(win11) * u1 * v1 + longint'(win10) * u * v1
      + longint'(win01) * u1 * v + longint'(win00) * u * v;
    rr = (t + 64'h8000_0000) >> 32;
    if (rr > 255) rr = 255;
    r = '{pixel: rr[7:0], last: (i == last_row_wr && j == last_col_wr), ovf: ovf_flag};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pix_res_t r;
    if (rst_n && in_valid && !in_stall) begin
      n_in++;
      if (downscale_step(in_pixel, in_first_of_frame, r))
        pix_expect.push_back(row_typed ? row_res : r);
    end
  end

  always @(posedge clk) begin
    pix_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (pix_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, actual pixel=%0d last=%0b ovf=%0b", $time,
                 out_pixel, out_last_of_frame, out_backlog_overflow);
      end else begin
        e = pix_expect.pop_front();
        if (out_pixel !== e.pixel) begin
          errors++;
          $display("%0t: pixel expected %0d actual %0d", $time, e.pixel, out_pixel);
        end
        if (out_last_of_frame !== e.last) begin
          errors++;
          $display("%0t: last_of_frame expected %0b actual %0b", $time, e.last,
                   out_last_of_frame);
        end
        if (out_backlog_overflow !== e.ovf) begin
          errors++;
          $display("%0t: backlog_overflow expected %0b actual %0b", $time, e.ovf,
                   out_backlog_overflow);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  task automatic send_pixel(logic [7:0] pix, logic first, logic typed, pix_res_t res);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_first_of_frame <= first;
    row_typed <= typed;
    row_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_set(logic [1:0] v);
    in_valid <= 1'b0;
    while (pix_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_LEVEL;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    set_level(v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  stim_row_t directed [] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{8'hAA, 1'b0, 1'b1, '{8'hAA, 1'b0, 1'b0}},
    '{8'h55, 1'b0, 1'b1, '{8'h55, 1'b0, 1'b0}},
    '{8'h01, 1'b1, 1'b1, '{8'h01, 1'b0, 1'b0}},
    '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b0, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b0, 1'b0}},
    '{8'hFE, 1'b0, 1'b1, '{8'hFE, 1'b0, 1'b0}}
  };

  initial begin
    int seg_len;
    set_level(2'd0);
    f_col = 0;
    g_row = 0;
    g_col = 0;
    win00 = '0; win01 = '0; win10 = '0; win11 = '0;
    last_pix = '0;
    ovf_flag = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k])
      send_pixel(directed[k].pixel, directed[k].first, directed[k].typed, directed[k].res);

    // Levels 1 and 2 run past the first source row so that interpolated pixels come out;
    // each frame restarts early in row zero with pixels still queued.
    for (int l = 1; l <= 3; l++) begin
      drain_and_set(2'(l));
      seg_len = (l == 3) ? 40 : W + 6 + $urandom_range(8, 24);
      for (int k = 0; k < seg_len; k++)
        send_pixel((k % 5 == 0) ? 8'hFF : 8'($urandom), (k == 0) || (k == 6), 1'b0, '0);
    end

    quiet = 1'b1;
    drain_and_set(2'd0);
    for (int k = 0; k < 20; k++) send_pixel(8'($urandom), k == 0, 1'b0, '0);
    in_valid <= 1'b0;

    while (pix_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d pixel transfers in and %0d out in passthrough and all",
             n_in, n_out);
    $display("three shrink levels, with early frame restarts and random stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
hdl/pbd_pkg.sv
hdl/pbd_ram.sv
hdl/pbd_interp.sv
hdl/pyramid_bilinear_downscaler.sv
hdl/pbd_checker.sv
bench/pyramid_bilinear_downscaler_tb.sv
